[hw/rtl/jasm_pkg.sv]
// ----------------------------------------------------------------------------
// jasm_pkg
// Shared types, widths and codes of the joystick axis smoothing and mapping
// unit.
// ----------------------------------------------------------------------------
package jasm_pkg;

    localparam int NUM_AXES_DEF  = 3;
    localparam int FRAC_BITS_DEF = 8;

    localparam int AXIS_W     = 2;
    localparam int SAMPLE_W   = 12;
    localparam int OFF_W      = 12;
    localparam int SOFT_W     = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int D_W        = 14;
    localparam int T_W        = 14;
    localparam int X_W        = 15;
    localparam int SPAN_W     = 14;
    localparam int DIFF_W     = 17;
    localparam int MUL_B_W    = 18;
    localparam int MAP_PROD_W = 32;

    localparam int ROUND_BIAS = 32768;
    localparam int OUT_HI     = 32767;
    localparam int OUT_LO     = -32768;

    localparam logic signed [T_W-1:0] HALF_FULL = 14'sd2048;
    localparam logic signed [T_W-1:0] HALF_LOW  = 14'sd512;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOFTNESS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIDDLE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX         = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_BLEND,
        ST_MAP,
        ST_MUL_MAP,
        ST_DIV_START,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[hw/rtl/jasm_if.sv]
// ----------------------------------------------------------------------------
// jasm_if
// Valid/ready channels of the joystick axis unit: sample input, mapped
// result output and register write port.
// ----------------------------------------------------------------------------
interface jasm_in_if;
    logic                             valid;
    logic                             ready;
    logic [jasm_pkg::AXIS_W-1:0]      axis;
    logic [jasm_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output axis, output sample, input ready);
    modport sink   (input valid, input axis, input sample, output ready);
endinterface

interface jasm_out_if;
    logic                             valid;
    logic                             ready;
    logic [jasm_pkg::AXIS_W-1:0]      axis_out;
    logic signed [jasm_pkg::OUT_W-1:0] mapped_value;

    modport source (output valid, output axis_out, output mapped_value, input ready);
    modport sink   (input valid, input axis_out, input mapped_value, output ready);
endinterface

interface jasm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [jasm_pkg::CFG_IDX_W-1:0]   index;
    logic [jasm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/jasm_mul.sv]
// ----------------------------------------------------------------------------
// jasm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module jasm_mul #(
    parameter int A_W = jasm_pkg::D_W + jasm_pkg::FRAC_BITS_DEF,
    parameter int B_W = jasm_pkg::MUL_B_W
) (
    input  logic                   i_clk,
    input  logic signed [A_W-1:0]  i_a,
    input  logic signed [B_W-1:0]  i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[hw/rtl/jasm_div.sv]
// ----------------------------------------------------------------------------
// jasm_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module jasm_div #(
    parameter int NUM_W = jasm_pkg::MAP_PROD_W,
    parameter int DEN_W = jasm_pkg::SPAN_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic signed [DEN_W-1:0]  i_den,
    output logic                     o_busy,
    output logic                     o_done,
    output logic signed [NUM_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_neg, n_neg;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_q, n_q;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_q[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W - 1);
            n_q    = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            n_rem  = '0;
            n_den  = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            n_neg  = i_num[NUM_W-1] ^ i_den[DEN_W-1];
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_diff[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

[hw/rtl/joystick_axis_smooth_map_unit.sv]
// ----------------------------------------------------------------------------
// joystick_axis_smooth_map_unit
// Per-axis exponential smoothing of joystick samples followed by a two-segment
// linear map around half scale, saturated to 16 bits.
//
//   Channel   Role      Payload
//   i_in      sink      axis, sample
//   o_out     source    axis_out, mapped_value
//   i_cfg     sink      index, data (register write)
//
// An accepted sample beat runs the sequencing states with three shared
// multiplier passes, then the 32-step divider, then the load. A zero-width
// segment skips the divider and loads the middle output; a sample on an axis
// with no level goes straight to the load. Input is ready again the cycle after
// the load. Reset clears the smoothed levels and loads register defaults. A
// stalled result is held in the output register while the next sample runs.
// ----------------------------------------------------------------------------
module joystick_axis_smooth_map_unit #(
    parameter int NUM_AXES  = jasm_pkg::NUM_AXES_DEF,
    parameter int FRAC_BITS = jasm_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jasm_in_if.sink       i_in,
    jasm_out_if.source    o_out,
    jasm_cfg_if.sink      i_cfg
);

    localparam int LW    = jasm_pkg::D_W + FRAC_BITS;
    localparam int PW    = LW + jasm_pkg::MUL_B_W;
    localparam int ACC_W = PW + 1;
    localparam int DW    = jasm_pkg::MAP_PROD_W;
    localparam int SCL_W = jasm_pkg::SOFT_W;

    jasm_pkg::t_state r_state, n_state;

    logic signed [jasm_pkg::OFF_W-1:0]  r_off_x, r_off_y, r_off_z;
    logic [SCL_W-1:0]                   r_soft;
    logic                               r_mode;
    logic signed [jasm_pkg::OUT_W-1:0]  r_out_min, r_out_mid, r_out_max;

    logic signed [LW-1:0] r_level [NUM_AXES];

    logic [jasm_pkg::AXIS_W-1:0]         r_axis, n_axis;
    logic signed [jasm_pkg::D_W-1:0]     r_d, n_d;
    logic signed [jasm_pkg::OFF_W-1:0]   r_off, n_off;
    logic signed [LW-1:0]                r_lvl, n_lvl;
    logic signed [PW-1:0]                r_acc, n_acc;
    logic signed [jasm_pkg::X_W-1:0]     r_x, n_x;
    logic signed [jasm_pkg::SPAN_W-1:0]  r_span, n_span;
    logic signed [jasm_pkg::DIFF_W-1:0]  r_diff, n_diff;
    logic signed [jasm_pkg::OUT_W-1:0]   r_olo, n_olo;
    logic signed [jasm_pkg::OUT_W-1:0]   r_res, n_res;
    logic                                r_zero, n_zero;

    logic                                r_out_valid;
    logic [jasm_pkg::AXIS_W-1:0]         r_out_axis;
    logic signed [jasm_pkg::OUT_W-1:0]   r_out_value;

    logic                                w_accept;
    logic                                w_bad;
    logic                                w_load;
    logic                                w_lvl_we;
    logic signed [jasm_pkg::OFF_W-1:0]   w_off;
    logic signed [LW-1:0]                w_prev;
    logic signed [LW-1:0]                w_mul_a;
    logic signed [jasm_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [PW-1:0]                w_mul_p;
    logic [SCL_W:0]                      w_wnew;
    logic signed [ACC_W-1:0]             w_sum;
    logic signed [LW-1:0]                w_new_lvl;
    logic signed [LW-1:0]                w_lvl_adj;
    logic signed [jasm_pkg::T_W-1:0]     w_t;
    logic signed [jasm_pkg::T_W-1:0]     w_half;
    logic                                w_div_start;
    logic                                w_div_busy;
    logic                                w_div_done;
    logic signed [DW-1:0]                w_div_q;
    logic signed [DW:0]                  w_res_full;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_bad    = (32'(i_in.axis) >= NUM_AXES);
    assign w_load   = (r_state == jasm_pkg::ST_OUT) && (!r_out_valid || o_out.ready);
    assign w_lvl_we = (r_state == jasm_pkg::ST_BLEND);

    assign i_in.ready   = (r_state == jasm_pkg::ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.axis_out     = r_out_axis;
    assign o_out.mapped_value = r_out_value;

    jasm_mul #(
        .A_W (LW),
        .B_W (jasm_pkg::MUL_B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    jasm_div #(
        .NUM_W (DW),
        .DEN_W (jasm_pkg::SPAN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mul_p[DW-1:0]),
        .i_den   (r_span),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            jasm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_bad ? jasm_pkg::ST_OUT : jasm_pkg::ST_MUL_NEW;
                end
            end
            jasm_pkg::ST_MUL_NEW: n_state = jasm_pkg::ST_MUL_OLD;
            jasm_pkg::ST_MUL_OLD: n_state = jasm_pkg::ST_BLEND;
            jasm_pkg::ST_BLEND:   n_state = jasm_pkg::ST_MAP;
            jasm_pkg::ST_MAP:     n_state = jasm_pkg::ST_MUL_MAP;
            jasm_pkg::ST_MUL_MAP: n_state = jasm_pkg::ST_DIV_START;
            jasm_pkg::ST_DIV_START: begin
                n_state = r_zero ? jasm_pkg::ST_OUT : jasm_pkg::ST_DIV;
            end
            jasm_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = jasm_pkg::ST_OUT;
                end
            end
            jasm_pkg::ST_OUT: begin
                if (w_load) begin
                    n_state = jasm_pkg::ST_IDLE;
                end
            end
            default: n_state = jasm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        case (i_in.axis)
            jasm_pkg::AXIS_X: w_off = r_off_x;
            jasm_pkg::AXIS_Y: w_off = r_off_y;
            jasm_pkg::AXIS_Z: w_off = r_off_z;
            default:          w_off = '0;
        endcase
        w_prev = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (32'(i_in.axis) == i) begin
                w_prev = r_level[i];
            end
        end

        w_wnew     = (SCL_W+1)'(1 << SCL_W) - {1'b0, r_soft};
        w_sum      = ACC_W'(r_acc) + ACC_W'(w_mul_p) + ACC_W'(jasm_pkg::ROUND_BIAS);
        w_new_lvl  = w_sum[SCL_W +: LW];
        w_lvl_adj  = r_lvl + (r_lvl[LW-1] ? LW'((1 << FRAC_BITS) - 1) : LW'(0));
        w_t        = w_lvl_adj[FRAC_BITS +: jasm_pkg::T_W];
        w_half     = r_mode ? jasm_pkg::HALF_FULL : jasm_pkg::HALF_LOW;
        w_res_full = (DW+1)'(w_div_q) + (DW+1)'(r_olo);

        case (r_state)
            jasm_pkg::ST_MUL_NEW: begin
                w_mul_a = {r_d, {FRAC_BITS{1'b0}}};
                w_mul_b = $signed({1'b0, w_wnew});
            end
            jasm_pkg::ST_MUL_OLD: begin
                w_mul_a = r_lvl;
                w_mul_b = $signed({2'b00, r_soft});
            end
            jasm_pkg::ST_MUL_MAP: begin
                w_mul_a = LW'(r_x);
                w_mul_b = jasm_pkg::MUL_B_W'(r_diff);
            end
            default: begin
                w_mul_a = r_lvl;
                w_mul_b = '0;
            end
        endcase

        w_div_start = (r_state == jasm_pkg::ST_DIV_START) && !r_zero;

        n_axis = r_axis;
        n_d    = r_d;
        n_off  = r_off;
        n_lvl  = r_lvl;
        n_acc  = r_acc;
        n_x    = r_x;
        n_span = r_span;
        n_diff = r_diff;
        n_olo  = r_olo;
        n_zero = r_zero;
        n_res  = r_res;
        case (r_state)
            jasm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_axis = i_in.axis;
                    n_off  = w_off;
                    n_d    = $signed({2'b00, i_in.sample}) - jasm_pkg::D_W'(w_off);
                    n_lvl  = w_prev;
                    n_res  = '0;
                end
            end
            jasm_pkg::ST_MUL_OLD: n_acc = w_mul_p;
            jasm_pkg::ST_BLEND:   n_lvl = w_new_lvl;
            jasm_pkg::ST_MAP: begin
                if (w_t >= w_half) begin
                    n_x    = jasm_pkg::X_W'(w_t) - jasm_pkg::X_W'(w_half);
                    n_span = w_half - jasm_pkg::SPAN_W'(r_off);
                    n_diff = jasm_pkg::DIFF_W'(r_out_max) - jasm_pkg::DIFF_W'(r_out_mid);
                    n_olo  = r_out_mid;
                end else begin
                    n_x    = jasm_pkg::X_W'(w_t) + jasm_pkg::X_W'(r_off);
                    n_span = w_half + jasm_pkg::SPAN_W'(r_off);
                    n_diff = jasm_pkg::DIFF_W'(r_out_mid) - jasm_pkg::DIFF_W'(r_out_min);
                    n_olo  = r_out_min;
                end
                n_zero = (n_span == '0);
            end
            jasm_pkg::ST_DIV_START: begin
                if (r_zero) begin
                    n_res = r_out_mid;
                end
            end
            jasm_pkg::ST_DIV: begin
                if (w_div_done) begin
                    if (w_res_full > (DW+1)'(jasm_pkg::OUT_HI)) begin
                        n_res = jasm_pkg::OUT_W'(jasm_pkg::OUT_HI);
                    end else if (w_res_full < (DW+1)'(jasm_pkg::OUT_LO)) begin
                        n_res = jasm_pkg::OUT_W'(jasm_pkg::OUT_LO);
                    end else begin
                        n_res = w_res_full[jasm_pkg::OUT_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jasm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_off_z     <= '0;
            r_soft      <= '0;
            r_mode      <= 1'b1;
            r_out_min   <= 16'sd0;
            r_out_mid   <= 16'sd512;
            r_out_max   <= 16'sd1023;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_level[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    jasm_pkg::REG_ZERO_OFFSET_X:   r_off_x   <= i_cfg.data[jasm_pkg::OFF_W-1:0];
                    jasm_pkg::REG_ZERO_OFFSET_Y:   r_off_y   <= i_cfg.data[jasm_pkg::OFF_W-1:0];
                    jasm_pkg::REG_ZERO_OFFSET_Z:   r_off_z   <= i_cfg.data[jasm_pkg::OFF_W-1:0];
                    jasm_pkg::REG_SOFTNESS:        r_soft    <= i_cfg.data;
                    jasm_pkg::REG_RESOLUTION_MODE: r_mode    <= i_cfg.data[0];
                    jasm_pkg::REG_OUT_MIN:         r_out_min <= i_cfg.data;
                    jasm_pkg::REG_OUT_MIDDLE:      r_out_mid <= i_cfg.data;
                    jasm_pkg::REG_OUT_MAX:         r_out_max <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            for (int i = 0; i < NUM_AXES; i++) begin
                if (w_lvl_we && (32'(r_axis) == i)) begin
                    r_level[i] <= w_new_lvl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis <= n_axis;
        r_d    <= n_d;
        r_off  <= n_off;
        r_lvl  <= n_lvl;
        r_acc  <= n_acc;
        r_x    <= n_x;
        r_span <= n_span;
        r_diff <= n_diff;
        r_olo  <= n_olo;
        r_zero <= n_zero;
        r_res  <= n_res;
        if (w_load) begin
            r_out_axis  <= r_axis;
            r_out_value <= r_res;
        end
    end

`ifndef SYNTH
    a_div_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jasm_pkg::ST_IDLE) |-> !w_div_busy)
        else $error("divider busy while the sequencer is idle");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == jasm_pkg::ST_DIV))
        else $error("divider finished outside the divide step");

    a_bad_axis_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_bad) |=> (r_state == jasm_pkg::ST_OUT && r_res == '0))
        else $error("sample on an axis without a level did not go straight to output");

    a_level_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lvl_we |=> !w_lvl_we)
        else $error("smoothed level written twice for one beat");
`endif

endmodule
